// File: rtl/mseu_pkg.sv
package mseu_pkg;

  localparam int XLEN       = 32;
  localparam int RF_DEPTH   = 32;
  localparam int RF_AW      = 5;
  localparam int DMEM_WORDS = 1024;
  localparam int DMEM_AW    = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;
  localparam int CFG_IDX_W  = 2;
  localparam int PLEN_W     = 16;

  localparam logic [XLEN-1:0] TEXT_START_RST = 32'h0040_0000;
  localparam logic [XLEN-1:0] DATA_START_RST = 32'h1000_0000;
  localparam logic [PLEN_W-1:0] PLEN_RST     = 16'h0000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd2;

  // primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTIU = 6'h0b;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2b;

  // r-type function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  localparam logic [RF_AW-1:0] REG_ZERO = 5'd0;
  localparam logic [RF_AW-1:0] REG_RA   = 5'd31;

  typedef struct packed {
    logic [XLEN-1:0]  next_pc;
    logic             halted;
    logic             bad_instr;
    logic             reg_write;
    logic [RF_AW-1:0] reg_index;
    logic [XLEN-1:0]  reg_value;
    logic             mem_write;
    logic [XLEN-1:0]  mem_addr;
    logic [XLEN-1:0]  mem_value;
  } result_t;

endpackage

// File: rtl/mseu_instr_if.sv
interface mseu_instr_if;
  logic                     valid;
  logic                     ready;
  logic [mseu_pkg::XLEN-1:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

// File: rtl/mseu_result_if.sv
interface mseu_result_if;
  logic                       valid;
  logic                       ready;
  logic [mseu_pkg::XLEN-1:0]  next_pc;
  logic                       halted;
  logic                       bad_instr;
  logic                       reg_write;
  logic [mseu_pkg::RF_AW-1:0] reg_index;
  logic [mseu_pkg::XLEN-1:0]  reg_value;
  logic                       mem_write;
  logic [mseu_pkg::XLEN-1:0]  mem_addr;
  logic [mseu_pkg::XLEN-1:0]  mem_value;

  modport source (
    output valid, output next_pc, output halted, output bad_instr, output reg_write,
    output reg_index, output reg_value, output mem_write, output mem_addr,
    output mem_value, input ready
  );
  modport sink (
    input valid, input next_pc, input halted, input bad_instr, input reg_write,
    input reg_index, input reg_value, input mem_write, input mem_addr,
    input mem_value, output ready
  );
endinterface

// File: rtl/mips_subset_execute_unit.sv
// channel    | dir | transfer moves                  | width
// -----------+-----+---------------------------------+------------------------------
// instr_i    | in  | one instruction word            | 32
// result_o   | out | next pc, flags, reg/mem write   | 32+1+1+1+5+32+1+32+32
// cfg_*_i    | in  | register write, no handshake    | idx 2, data 32
//
// one instruction per cycle back to back while result_o takes results; a lw goes
// on to the data memory read stage, and the one behind it waits until the lw leaves
// register file reads are issued from the input word at the transfer; the most
// recent write is forwarded around the registered read
// after reset the data memory is swept to zero, all DMEM_WORDS (1024) words, with
// instr_i not ready; configuration writes are taken during the sweep
// a stalled result_o holds in the output register; the next instruction waits in
// execute (a lw goes on to the data stage) and writes into it once it drains
module mips_subset_execute_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mseu_instr_if.sink                        instr_i,
  mseu_result_if.source                     result_o,
  input  logic                              cfg_we_i,
  input  logic [mseu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mseu_pkg::XLEN-1:0]         cfg_wdata_i
);

  localparam int Aw = mseu_pkg::DMEM_AW;

  // configuration and architectural pc
  logic [mseu_pkg::XLEN-1:0]   text_start_q;
  logic [mseu_pkg::PLEN_W-1:0] prog_len_q;
  logic [mseu_pkg::XLEN-1:0]   data_start_q;
  logic [mseu_pkg::XLEN-1:0]   end_pc_q;
  logic [mseu_pkg::XLEN-1:0]   pc_q;

  // data memory clearing sweep
  logic          clr_busy_q;
  logic [Aw-1:0] clr_cnt_q;

  // execute stage
  logic                      ex_valid_q;
  logic [mseu_pkg::XLEN-1:0] ex_instr_q;

  // load data stage
  logic                        m_valid_q;
  logic [mseu_pkg::RF_AW-1:0]  m_rt_q;
  logic [mseu_pkg::XLEN-1:0]   m_addr_q;
  logic                        m_hit_q;
  logic [Aw-1:0]               m_idx_q;
  logic [mseu_pkg::XLEN-1:0]   m_npc_q;

  // register file valid bits and last-write bypass
  logic [mseu_pkg::RF_DEPTH-1:0] rf_vld_q;
  logic                          byp_en_q;
  logic [mseu_pkg::RF_AW-1:0]    byp_idx_q;
  logic [mseu_pkg::XLEN-1:0]     byp_val_q;

  // output register
  logic                  out_valid_q;
  mseu_pkg::result_t     out_q;
  mseu_pkg::result_t     out_d;

  // handshake
  logic in_xfer, out_free, ex_fire, m_fire, ex_to_m;

  // register file ports
  logic [mseu_pkg::RF_AW-1:0] rs_raddr, rt_raddr;
  logic [mseu_pkg::XLEN-1:0]  rs_rdata, rt_rdata;
  logic                       rf_we;
  logic [mseu_pkg::RF_AW-1:0] rf_waddr;
  logic [mseu_pkg::XLEN-1:0]  rf_wdata;

  // data memory ports
  logic                      dm_we;
  logic [Aw-1:0]             dm_waddr, dm_raddr;
  logic [mseu_pkg::XLEN-1:0] dm_wdata, dm_rdata;

  // decode and execute
  logic [5:0]                 op, fn;
  logic [mseu_pkg::RF_AW-1:0] rs, rt, rd, sh;
  logic [mseu_pkg::XLEN-1:0]  simm, zimm, op_a, op_b;
  logic [mseu_pkg::XLEN-1:0]  pc_plus4, pc_plus8, baddr, jaddr, maddr, moff;
  logic [mseu_pkg::XLEN-3:0]  word_idx;
  logic                       dm_hit, ex_halt;
  logic                       ex_wr, ex_bad, ex_is_lw, ex_is_sw;
  logic [mseu_pkg::RF_AW-1:0] ex_widx;
  logic [mseu_pkg::XLEN-1:0]  ex_wval, ex_npc;
  logic                       ex_rf_we;
  mseu_pkg::result_t          ex_res, m_res;
  logic [mseu_pkg::XLEN-1:0]  m_val;
  logic                       m_rf_we;

  // ---------------------------------------------------------------------------
  // handshake and stage control
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_q || result_o.ready;
  assign ex_to_m  = ex_is_lw && !ex_halt;
  // the output register has one writer per cycle: execute waits while a load
  // sits in the data stage
  assign ex_fire  = ex_valid_q && !m_valid_q && (ex_to_m || out_free);
  assign m_fire   = m_valid_q && out_free;

  assign instr_i.ready = !clr_busy_q && (!ex_valid_q || ex_fire);
  assign in_xfer       = instr_i.valid && instr_i.ready;

  // ---------------------------------------------------------------------------
  // register file: two copies for the rs and rt read ports, written together
  // ---------------------------------------------------------------------------
  // reads are re-issued each cycle for a held instruction, so a stalled one
  // stays coherent with writes that land meanwhile
  assign rs_raddr = in_xfer ? instr_i.instr_word[25:21] : ex_instr_q[25:21];
  assign rt_raddr = in_xfer ? instr_i.instr_word[20:16] : ex_instr_q[20:16];

  mseu_ram #(
    .Width(mseu_pkg::XLEN),
    .Depth(mseu_pkg::RF_DEPTH)
  ) u_rf_rs (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rs_raddr),
    .rdata_o (rs_rdata)
  );

  mseu_ram #(
    .Width(mseu_pkg::XLEN),
    .Depth(mseu_pkg::RF_DEPTH)
  ) u_rf_rt (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rt_raddr),
    .rdata_o (rt_rdata)
  );

  // ---------------------------------------------------------------------------
  // operand fetch with bypass of the write that raced the read
  // ---------------------------------------------------------------------------
  assign op = ex_instr_q[31:26];
  assign rs = ex_instr_q[25:21];
  assign rt = ex_instr_q[20:16];
  assign rd = ex_instr_q[15:11];
  assign sh = ex_instr_q[10:6];
  assign fn = ex_instr_q[5:0];
  assign simm = {{16{ex_instr_q[15]}}, ex_instr_q[15:0]};
  assign zimm = {16'h0000, ex_instr_q[15:0]};

  always_comb begin
    if (byp_en_q && (byp_idx_q == rs)) begin
      op_a = byp_val_q;
    end else if (rf_vld_q[rs]) begin
      op_a = rs_rdata;
    end else begin
      op_a = '0;
    end
    if (byp_en_q && (byp_idx_q == rt)) begin
      op_b = byp_val_q;
    end else if (rf_vld_q[rt]) begin
      op_b = rt_rdata;
    end else begin
      op_b = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // address arithmetic, all modulo 2^32
  // ---------------------------------------------------------------------------
  assign pc_plus4 = pc_q + 32'd4;
  assign pc_plus8 = pc_q + 32'd8;
  assign baddr    = pc_plus4 + {simm[29:0], 2'b00};
  assign jaddr    = {pc_q[31:28], ex_instr_q[25:0], 2'b00};
  assign maddr    = op_a + simm;
  assign moff     = maddr - data_start_q;
  assign word_idx = moff[31:2];
  assign dm_hit   = word_idx < (mseu_pkg::XLEN-2)'(mseu_pkg::DMEM_WORDS);
  assign ex_halt  = (pc_q == end_pc_q);

  // ---------------------------------------------------------------------------
  // decode and alu
  // ---------------------------------------------------------------------------
  always_comb begin
    ex_wr    = 1'b0;
    ex_widx  = rt;
    ex_wval  = '0;
    ex_bad   = 1'b0;
    ex_npc   = pc_plus4;
    ex_is_lw = 1'b0;
    ex_is_sw = 1'b0;
    unique case (op)
      mseu_pkg::OP_RTYPE: begin
        ex_wr   = 1'b1;
        ex_widx = rd;
        unique case (fn)
          mseu_pkg::FN_ADDU: ex_wval = op_a + op_b;
          mseu_pkg::FN_SUBU: ex_wval = op_a - op_b;
          mseu_pkg::FN_AND:  ex_wval = op_a & op_b;
          mseu_pkg::FN_OR:   ex_wval = op_a | op_b;
          mseu_pkg::FN_NOR:  ex_wval = ~(op_a | op_b);
          mseu_pkg::FN_SLTU: ex_wval = {31'd0, op_a < op_b};
          mseu_pkg::FN_SLL:  ex_wval = op_b << sh;
          mseu_pkg::FN_SRL:  ex_wval = op_b >> sh;
          mseu_pkg::FN_JR: begin
            ex_wr  = 1'b0;
            ex_npc = op_a;
          end
          default: begin
            ex_wr  = 1'b0;
            ex_bad = 1'b1;
          end
        endcase
      end
      mseu_pkg::OP_ADDIU: begin
        ex_wr   = 1'b1;
        ex_wval = op_a + simm;
      end
      mseu_pkg::OP_ANDI: begin
        ex_wr   = 1'b1;
        ex_wval = op_a & zimm;
      end
      mseu_pkg::OP_ORI: begin
        ex_wr   = 1'b1;
        ex_wval = op_a | zimm;
      end
      mseu_pkg::OP_LUI: begin
        ex_wr   = 1'b1;
        ex_wval = {ex_instr_q[15:0], 16'h0000};
      end
      mseu_pkg::OP_SLTIU: begin
        ex_wr   = 1'b1;
        ex_wval = {31'd0, op_a < simm};
      end
      mseu_pkg::OP_LW: ex_is_lw = 1'b1;
      mseu_pkg::OP_SW: ex_is_sw = 1'b1;
      mseu_pkg::OP_BEQ: begin
        if (op_a == op_b) begin
          ex_npc = baddr;
        end
      end
      mseu_pkg::OP_BNE: begin
        if (op_a != op_b) begin
          ex_npc = baddr;
        end
      end
      mseu_pkg::OP_J: ex_npc = jaddr;
      mseu_pkg::OP_JAL: begin
        ex_wr   = 1'b1;
        ex_widx = mseu_pkg::REG_RA;
        ex_wval = pc_plus8;
        ex_npc  = jaddr;
      end
      default: ex_bad = 1'b1;
    endcase
  end

  // writes to register zero are dropped and not reported
  assign ex_rf_we = ex_wr && (ex_widx != mseu_pkg::REG_ZERO) && !ex_halt && !ex_bad;

  // result of everything that finishes in execute
  always_comb begin
    ex_res = '0;
    if (ex_halt) begin
      ex_res.next_pc = pc_q;
      ex_res.halted  = 1'b1;
    end else if (ex_bad) begin
      ex_res.next_pc   = pc_q;
      ex_res.bad_instr = 1'b1;
    end else begin
      ex_res.next_pc   = ex_npc;
      ex_res.reg_write = ex_rf_we;
      ex_res.reg_index = ex_rf_we ? ex_widx : mseu_pkg::REG_ZERO;
      ex_res.reg_value = ex_rf_we ? ex_wval : '0;
      ex_res.mem_write = ex_is_sw && dm_hit;
      ex_res.mem_addr  = ex_is_sw ? maddr : '0;
      ex_res.mem_value = ex_is_sw ? op_b : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // data memory: clearing sweep, stores from execute, loads read in execute
  // and picked up from the registered read in the load data stage later
  // ---------------------------------------------------------------------------
  assign dm_we    = clr_busy_q || (ex_fire && ex_is_sw && dm_hit && !ex_halt);
  assign dm_waddr = clr_busy_q ? clr_cnt_q : word_idx[Aw-1:0];
  assign dm_wdata = clr_busy_q ? '0 : op_b;
  // a waiting load keeps its address on the port so its data holds
  assign dm_raddr = (ex_fire && ex_to_m) ? word_idx[Aw-1:0] : m_idx_q;

  mseu_ram #(
    .Width(mseu_pkg::XLEN),
    .Depth(mseu_pkg::DMEM_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .raddr_i (dm_raddr),
    .rdata_o (dm_rdata)
  );

  // load result, an address outside the memory loads zero
  assign m_val   = m_hit_q ? dm_rdata : '0;
  assign m_rf_we = (m_rt_q != mseu_pkg::REG_ZERO);

  always_comb begin
    m_res           = '0;
    m_res.next_pc   = m_npc_q;
    m_res.reg_write = m_rf_we;
    m_res.reg_index = m_rf_we ? m_rt_q : mseu_pkg::REG_ZERO;
    m_res.reg_value = m_rf_we ? m_val : '0;
    m_res.mem_addr  = m_addr_q;
    m_res.mem_value = m_val;
  end

  // register file write: load data stage or execute, never both in one cycle
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = ex_widx;
    rf_wdata = ex_wval;
    if (m_fire && m_rf_we) begin
      rf_we    = 1'b1;
      rf_waddr = m_rt_q;
      rf_wdata = m_val;
    end else if (ex_fire && ex_rf_we) begin
      rf_we = 1'b1;
    end
  end

  // output register input
  always_comb begin
    out_d = out_q;
    if (m_fire) begin
      out_d = m_res;
    end else if (ex_fire && !ex_to_m) begin
      out_d = ex_res;
    end
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_start_q <= mseu_pkg::TEXT_START_RST;
      prog_len_q   <= mseu_pkg::PLEN_RST;
      data_start_q <= mseu_pkg::DATA_START_RST;
      end_pc_q     <= mseu_pkg::TEXT_START_RST;
      pc_q         <= mseu_pkg::TEXT_START_RST;
      clr_busy_q   <= 1'b1;
      clr_cnt_q    <= '0;
      ex_valid_q   <= 1'b0;
      m_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      rf_vld_q     <= '0;
      byp_en_q     <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == Aw'(mseu_pkg::DMEM_WORDS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end

      if (ex_fire && !ex_halt && !ex_bad) begin
        pc_q <= ex_npc;
      end

      // configuration, the end-of-program pc is kept precomputed
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mseu_pkg::CFG_TEXT_START: begin
            text_start_q <= cfg_wdata_i;
            pc_q         <= cfg_wdata_i;
            end_pc_q     <= cfg_wdata_i + {14'd0, prog_len_q, 2'b00};
          end
          mseu_pkg::CFG_PROG_LEN: begin
            prog_len_q <= cfg_wdata_i[mseu_pkg::PLEN_W-1:0];
            end_pc_q   <= text_start_q + {14'd0, cfg_wdata_i[mseu_pkg::PLEN_W-1:0], 2'b00};
          end
          mseu_pkg::CFG_DATA_START: data_start_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (in_xfer) begin
        ex_valid_q <= 1'b1;
      end else if (ex_fire) begin
        ex_valid_q <= 1'b0;
      end

      if (ex_fire && ex_to_m) begin
        m_valid_q <= 1'b1;
      end else if (m_fire) begin
        m_valid_q <= 1'b0;
      end

      out_valid_q <= (out_valid_q && !result_o.ready) || m_fire || (ex_fire && !ex_to_m);

      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
        byp_en_q           <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ex_instr_q <= instr_i.instr_word;
    end
    if (ex_fire && ex_to_m) begin
      m_rt_q   <= rt;
      m_addr_q <= maddr;
      m_hit_q  <= dm_hit;
      m_idx_q  <= word_idx[Aw-1:0];
      m_npc_q  <= pc_plus4;
    end
    if (rf_we) begin
      byp_idx_q <= rf_waddr;
      byp_val_q <= rf_wdata;
    end
    out_q <= out_d;
  end

  // ---------------------------------------------------------------------------
  // result port
  // ---------------------------------------------------------------------------
  assign result_o.valid     = out_valid_q;
  assign result_o.next_pc   = out_q.next_pc;
  assign result_o.halted    = out_q.halted;
  assign result_o.bad_instr = out_q.bad_instr;
  assign result_o.reg_write = out_q.reg_write;
  assign result_o.reg_index = out_q.reg_index;
  assign result_o.reg_value = out_q.reg_value;
  assign result_o.mem_write = out_q.mem_write;
  assign result_o.mem_addr  = out_q.mem_addr;
  assign result_o.mem_value = out_q.mem_value;

endmodule

// File: rtl/mseu_ram.sv
module mseu_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read before write on a shared address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: test/tb_mips_subset_execute_unit.sv
`timescale 1ns / 1ps

module tb_mips_subset_execute_unit;
  import mseu_pkg::*;

  // encodings that no supported instruction uses
  localparam logic [5:0] OP_UNDEF = 6'h3f;
  localparam logic [5:0] FN_UNDEF = 6'h3f;

  // cycles without any transfer before the run is declared hung
  // (covers the data memory sweep after reset with a wide margin)
  localparam int STALL_LIMIT = 5000;
  localparam int PRINT_CAP   = 100;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_wdata;
  logic        no_gaps;

  mseu_instr_if  instr_ch ();
  mseu_result_if result_ch ();

  mips_subset_execute_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .instr_i    (instr_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // instruction words waiting for the driver, and retirement records predicted
  // for accepted words that have not come out yet
  logic [31:0] fetch_queue[$];
  result_t     predicted_retire[$];

  // architectural state as the testbench sees it
  logic [31:0] cfg_text;
  logic [15:0] cfg_plen;
  logic [31:0] cfg_data;
  logic [31:0] arch_pc;
  logic [31:0] gpr [32];
  logic [31:0] dmem [DMEM_WORDS];

  int mismatch_count;
  int stall_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // instruction encoders
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sh);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] target);
    return {op, target};
  endfunction

  // ---------------------------------------------------------------------------
  // architectural model
  // ---------------------------------------------------------------------------
  function automatic void arch_reset();
    cfg_text = TEXT_START_RST;
    cfg_plen = PLEN_RST;
    cfg_data = DATA_START_RST;
    arch_pc  = TEXT_START_RST;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    for (int i = 0; i < DMEM_WORDS; i++) dmem[i] = '0;
  endfunction

  // executes one word at arch_pc, updates the state, returns the retirement record
  function automatic result_t execute_instr(input logic [31:0] iw);
    result_t     res;
    logic [4:0]  rs, rt, rd, sh, widx;
    logic [15:0] imm;
    logic [31:0] a, b, simm, npc, wval, maddr, mval, word;
    logic        wr, bad, mw;
    rs    = iw[25:21];
    rt    = iw[20:16];
    rd    = iw[15:11];
    sh    = iw[10:6];
    imm   = iw[15:0];
    a     = gpr[rs];
    b     = gpr[rt];
    simm  = {{16{imm[15]}}, imm};
    npc   = arch_pc + 32'd4;
    wr    = 1'b0;
    bad   = 1'b0;
    mw    = 1'b0;
    widx  = REG_ZERO;
    wval  = '0;
    maddr = '0;
    mval  = '0;
    res   = '0;

    // pc at end of program: word is ignored, pc stays
    if (arch_pc == cfg_text + {14'd0, cfg_plen, 2'b00}) begin
      res.next_pc = arch_pc;
      res.halted  = 1'b1;
      return res;
    end

    case (iw[31:26])
      OP_RTYPE: begin
        wr   = 1'b1;
        widx = rd;
        case (iw[5:0])
          FN_ADDU: wval = a + b;
          FN_SUBU: wval = a - b;
          FN_AND:  wval = a & b;
          FN_OR:   wval = a | b;
          FN_NOR:  wval = ~(a | b);
          FN_SLTU: wval = {31'd0, a < b};
          FN_SLL:  wval = b << sh;
          FN_SRL:  wval = b >> sh;
          FN_JR: begin
            wr  = 1'b0;
            npc = a;
          end
          default: begin
            wr  = 1'b0;
            bad = 1'b1;
          end
        endcase
      end
      OP_ADDIU: begin wr = 1'b1; widx = rt; wval = a + simm; end
      OP_ANDI:  begin wr = 1'b1; widx = rt; wval = a & {16'd0, imm}; end
      OP_LUI:   begin wr = 1'b1; widx = rt; wval = {imm, 16'd0}; end
      OP_ORI:   begin wr = 1'b1; widx = rt; wval = a | {16'd0, imm}; end
      OP_SLTIU: begin wr = 1'b1; widx = rt; wval = {31'd0, a < simm}; end
      OP_LW: begin
        maddr = a + simm;
        word  = (maddr - cfg_data) >> 2;
        mval  = (word < DMEM_WORDS) ? dmem[word] : 32'd0;
        wr    = 1'b1;
        widx  = rt;
        wval  = mval;
      end
      OP_SW: begin
        maddr = a + simm;
        mval  = b;
        word  = (maddr - cfg_data) >> 2;
        // stores outside the data window are dropped
        if (word < DMEM_WORDS) begin
          dmem[word] = b;
          mw         = 1'b1;
        end
      end
      OP_BEQ: if (a == b) npc = arch_pc + 32'd4 + (simm << 2);
      OP_BNE: if (a != b) npc = arch_pc + 32'd4 + (simm << 2);
      OP_J:   npc = {arch_pc[31:28], iw[25:0], 2'b00};
      OP_JAL: begin
        wr   = 1'b1;
        widx = REG_RA;
        wval = arch_pc + 32'd8;
        npc  = {arch_pc[31:28], iw[25:0], 2'b00};
      end
      default: bad = 1'b1;
    endcase

    // unsupported word: nothing changes
    if (bad) begin
      res.next_pc   = arch_pc;
      res.bad_instr = 1'b1;
      return res;
    end

    // writes to register zero vanish
    if (wr && widx == REG_ZERO) wr = 1'b0;
    if (wr) gpr[widx] = wval;
    arch_pc = npc;

    res.next_pc   = npc;
    res.reg_write = wr;
    res.reg_index = wr ? widx : REG_ZERO;
    res.reg_value = wr ? wval : 32'd0;
    res.mem_write = mw;
    res.mem_addr  = maddr;
    res.mem_value = mval;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // random instruction mix: mostly well-formed words with random fields,
  // loads and stores mostly based on r1..r3, which point into or just below the data window
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rand_instr();
    logic [31:0] rw, rw2;
    logic [4:0]  dst, s1, s2, base;
    logic [5:0]  fn, op;
    logic [15:0] imm;
    int unsigned pick;
    rw   = $urandom();
    rw2  = $urandom();
    pick = $urandom_range(99);
    s1   = rw[9:5];
    s2   = rw[14:10];
    imm  = rw[31:16];
    dst  = rw[4:0];
    // keep the base registers alive most of the time
    if (dst < 5'd4 && rw2[31:30] != 2'b00) dst = dst | 5'd4;

    // plain noise, mostly unsupported encodings
    if (pick < 8) return rw2;

    if (pick < 36) begin
      case ($urandom_range(8))
        0:       fn = FN_ADDU;
        1:       fn = FN_SUBU;
        2:       fn = FN_AND;
        3:       fn = FN_OR;
        4:       fn = FN_NOR;
        5:       fn = FN_SLTU;
        6:       fn = FN_SLL;
        7:       fn = FN_SRL;
        default: fn = FN_JR;
      endcase
      return enc_r(fn, s1, s2, dst, rw2[4:0]);
    end

    if (pick < 56) begin
      case ($urandom_range(4))
        0:       op = OP_ADDIU;
        1:       op = OP_ANDI;
        2:       op = OP_LUI;
        3:       op = OP_ORI;
        default: op = OP_SLTIU;
      endcase
      return enc_i(op, s1, dst, imm);
    end

    if (pick < 80) begin
      base = (rw2[1:0] == 2'd0) ? 5'd1 : {3'd0, rw2[1:0]};
      if (rw2[4:2] == 3'd0) base = s1;
      // offsets mostly around the window, now and then anywhere
      if (rw2[7:5] != 3'd0) begin
        rw2 = $urandom_range(4200);
        imm = rw2[15:0];
      end
      if (rw[15])
        return enc_i(OP_LW, base, dst, imm);
      return enc_i(OP_SW, base, s2, imm);
    end

    if (pick < 93) begin
      if (rw2[1:0] == 2'd0) s2 = s1;
      if (rw2[2]) imm = {{10{rw2[8]}}, rw2[8:3]};
      return enc_i(rw[15] ? OP_BEQ : OP_BNE, s1, s2, imm);
    end

    return enc_j(rw[15] ? OP_J : OP_JAL, rw2[25:0]);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    // keep the log bounded when the block is badly broken
    if (mismatch_count < PRINT_CAP)
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_mismatch(name, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // configuration and phase control
  // ---------------------------------------------------------------------------
  // writes all three registers on consecutive edges; text_start also reloads pc
  task automatic set_config(input logic [31:0] text, input logic [15:0] plen,
                            input logic [31:0] data);
    logic [31:0] junk;
    junk = $urandom();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_TEXT_START;
    cfg_wdata <= text;
    @(posedge clk);
    cfg_idx   <= CFG_PROG_LEN;
    // upper bits are beyond the register and must be dropped
    cfg_wdata <= {junk[15:0], plen};
    @(posedge clk);
    cfg_idx   <= CFG_DATA_START;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_text = text;
    arch_pc  = text;
    cfg_plen = plen;
    cfg_data = data;
  endtask

  // block until every word has been sent and every retirement has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (fetch_queue.size() != 0 || instr_ch.valid || predicted_retire.size() != 0);
  endtask

  // r1 = data window start, r2 = middle of the window, r3 = just below it
  task automatic load_bases(input logic [31:0] ds);
    fetch_queue.push_back(enc_i(OP_LUI, REG_ZERO, 5'd1, ds[31:16]));
    fetch_queue.push_back(enc_i(OP_ORI, 5'd1, 5'd1, ds[15:0]));
    fetch_queue.push_back(enc_i(OP_ADDIU, 5'd1, 5'd2, 16'h0800));
    fetch_queue.push_back(enc_i(OP_ADDIU, 5'd1, 5'd3, 16'hfff8));
  endtask

  // ---------------------------------------------------------------------------
  // instruction driver: takes the next word once the current one transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      instr_ch.valid      <= 1'b0;
      instr_ch.instr_word <= '0;
    end else if (!instr_ch.valid || instr_ch.ready) begin
      if (fetch_queue.size() != 0 && (no_gaps || $urandom_range(99) >= 10)) begin
        instr_ch.valid      <= 1'b1;
        instr_ch.instr_word <= fetch_queue.pop_front();
      end else begin
        instr_ch.valid <= 1'b0;
      end
    end
  end

  // result sink with random back-pressure
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= no_gaps || ($urandom_range(99) >= 10);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on every instruction transfer, checks every result transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (instr_ch.valid && instr_ch.ready)
      predicted_retire.push_back(execute_instr(instr_ch.instr_word));
    if (result_ch.valid && result_ch.ready) begin
      if (predicted_retire.size() == 0) begin
        flag_mismatch("result with nothing outstanding", result_ch.next_pc, '0);
      end else begin
        want = predicted_retire.pop_front();
        check_field("next_pc", result_ch.next_pc, want.next_pc);
        check_field("halted", {31'd0, result_ch.halted}, {31'd0, want.halted});
        check_field("bad_instr", {31'd0, result_ch.bad_instr}, {31'd0, want.bad_instr});
        check_field("reg_write", {31'd0, result_ch.reg_write}, {31'd0, want.reg_write});
        check_field("reg_index", {27'd0, result_ch.reg_index}, {27'd0, want.reg_index});
        check_field("reg_value", result_ch.reg_value, want.reg_value);
        check_field("mem_write", {31'd0, result_ch.mem_write}, {31'd0, want.mem_write});
        check_field("mem_addr", result_ch.mem_addr, want.mem_addr);
        check_field("mem_value", result_ch.mem_value, want.mem_value);
      end
    end
  end

  // watchdog: no transfer of any kind for too long means the block hung
  always @(posedge clk) begin
    if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready) ||
        cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] rv_text, rv_data, rv_len;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_TEXT_START;
    cfg_wdata           = '0;
    no_gaps             = 1'b0;
    instr_ch.valid      = 1'b0;
    instr_ch.instr_word = '0;
    result_ch.ready     = 1'b0;
    mismatch_count      = 0;
    stall_cycles        = 0;
    arch_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: zero program length, so the first words hit the halt pc
    fetch_queue.push_back(enc_i(OP_ADDIU, REG_ZERO, 5'd1, 16'h0001));
    fetch_queue.push_back(32'hffff_ffff);
    wait_idle();

    // zero length written explicitly at a non-default text address
    set_config(32'h1234_5678, 16'd0, DATA_START_RST);
    fetch_queue.push_back(enc_i(OP_LUI, REG_ZERO, 5'd1, 16'h1000));
    wait_idle();

    // every operation with extreme operands, window edges, register zero
    set_config(TEXT_START_RST, 16'hffff, DATA_START_RST);
    fetch_queue.push_back(enc_i(OP_LUI, REG_ZERO, 5'd1, 16'h1000));
    fetch_queue.push_back(enc_i(OP_ADDIU, REG_ZERO, 5'd2, 16'hffff));
    fetch_queue.push_back(enc_i(OP_ADDIU, REG_ZERO, 5'd3, 16'h7fff));
    fetch_queue.push_back(enc_r(FN_ADDU, 5'd2, 5'd3, 5'd4, 5'd0));
    fetch_queue.push_back(enc_r(FN_SUBU, 5'd3, 5'd2, 5'd5, 5'd0));
    fetch_queue.push_back(enc_r(FN_AND, 5'd2, 5'd3, 5'd6, 5'd0));
    fetch_queue.push_back(enc_r(FN_OR, 5'd3, REG_ZERO, 5'd7, 5'd0));
    fetch_queue.push_back(enc_r(FN_NOR, 5'd3, REG_ZERO, 5'd8, 5'd0));
    fetch_queue.push_back(enc_r(FN_SLTU, 5'd3, 5'd2, 5'd9, 5'd0));
    fetch_queue.push_back(enc_r(FN_SLL, REG_ZERO, 5'd2, 5'd10, 5'd31));
    fetch_queue.push_back(enc_r(FN_SRL, REG_ZERO, 5'd2, 5'd11, 5'd31));
    fetch_queue.push_back(enc_i(OP_ANDI, 5'd2, 5'd12, 16'hffff));
    fetch_queue.push_back(enc_i(OP_ORI, REG_ZERO, 5'd13, 16'h8000));
    fetch_queue.push_back(enc_i(OP_SLTIU, 5'd3, 5'd14, 16'hffff));
    fetch_queue.push_back(enc_i(OP_SW, 5'd1, 5'd2, 16'h0000));
    fetch_queue.push_back(enc_i(OP_LW, 5'd1, 5'd15, 16'h0000));
    // last word of the window, then one past it, then one below it
    fetch_queue.push_back(enc_i(OP_SW, 5'd1, 5'd3, 16'h0ffc));
    fetch_queue.push_back(enc_i(OP_LW, 5'd1, 5'd16, 16'h0ffc));
    fetch_queue.push_back(enc_i(OP_SW, 5'd1, 5'd2, 16'h1000));
    fetch_queue.push_back(enc_i(OP_LW, 5'd1, 5'd17, 16'hfffc));
    // write to register zero is dropped
    fetch_queue.push_back(enc_i(OP_ADDIU, 5'd2, REG_ZERO, 16'h0001));
    fetch_queue.push_back(enc_i(OP_BEQ, 5'd2, 5'd2, 16'hfffe));
    fetch_queue.push_back(enc_i(OP_BNE, 5'd2, 5'd3, 16'h7fff));
    fetch_queue.push_back(enc_j(OP_JAL, 26'h3ff_ffff));
    fetch_queue.push_back(enc_j(OP_J, 26'h000_0000));
    fetch_queue.push_back(enc_r(FN_JR, REG_RA, REG_ZERO, REG_ZERO, 5'd0));
    fetch_queue.push_back({OP_UNDEF, 26'h2aa_aaaa});
    fetch_queue.push_back(enc_r(FN_UNDEF, 5'd2, 5'd3, 5'd4, 5'd0));
    wait_idle();

    // pc wraps past the top of the address space onto the halt pc
    set_config(32'hffff_fff8, 16'd2, 32'h0000_0000);
    fetch_queue.push_back(enc_i(OP_ADDIU, REG_ZERO, 5'd1, 16'h0001));
    fetch_queue.push_back(enc_i(OP_ADDIU, 5'd1, 5'd1, 16'h0001));
    fetch_queue.push_back(enc_i(OP_ADDIU, 5'd1, 5'd1, 16'h0001));
    fetch_queue.push_back(enc_i(OP_SW, 5'd1, 5'd1, 16'h0000));
    wait_idle();

    // jump register straight onto the halt pc
    set_config(32'h0000_0000, 16'd100, 32'hffff_ffff);
    fetch_queue.push_back(enc_i(OP_ORI, REG_ZERO, 5'd5, 16'd400));
    fetch_queue.push_back(enc_r(FN_JR, 5'd5, REG_ZERO, REG_ZERO, 5'd0));
    fetch_queue.push_back(enc_i(OP_ADDIU, REG_ZERO, 5'd6, 16'h0001));
    wait_idle();

    // random phases, each with its own layout; one runs without any gaps
    for (int ph = 0; ph < 5; ph++) begin
      rv_text = $urandom();
      rv_data = $urandom();
      rv_len  = $urandom_range(65535, 1024);
      case (ph)
        0:       set_config(TEXT_START_RST, 16'hffff, DATA_START_RST);
        1:       set_config(32'h0000_0000, 16'hffff, 32'h0000_0000);
        2:       set_config(32'hffff_ffff, 16'hffff, 32'hffff_ffff);
        3:       set_config({rv_text[31:2], 2'b00}, rv_len[15:0], rv_data);
        default: set_config(rv_text, 16'hffff, {rv_data[31:2], 2'b00});
      endcase
      no_gaps <= (ph == 1);
      load_bases(cfg_data);
      repeat (200) fetch_queue.push_back(rand_instr());
      wait_idle();
    end
    no_gaps <= 1'b0;

    // wait for anything late, then the verdict
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
